// ===== sv/dq_pkg.sv =====
// Shared types, codes and helpers for the double-ended queue.
// No dependencies; imported by double_ended_queue, dq_front, dq_queue and dq_back.
`timescale 1ns / 1ps

package dq_pkg;

  localparam int DEPTH      = 64;
  localparam int DATA_WIDTH = 32;
  localparam int PTR_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [2:0] OP_PUSH_FRONT  = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK   = 3'd1;
  localparam logic [2:0] OP_POP_FRONT   = 3'd2;
  localparam logic [2:0] OP_POP_BACK    = 3'd3;
  localparam logic [2:0] OP_PEEK_FRONT  = 3'd4;
  localparam logic [2:0] OP_PEEK_BACK   = 3'd5;
  localparam logic [2:0] OP_READ_INDEX  = 3'd6;
  localparam logic [2:0] OP_REMOVE_VAL  = 3'd7;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_EMPTY    = 2'd1;
  localparam logic [1:0] ST_FULL     = 2'd2;
  localparam logic [1:0] ST_NOTFOUND = 2'd3;

  localparam logic [2:0] K_PUSH   = 3'd0;
  localparam logic [2:0] K_POP    = 3'd1;
  localparam logic [2:0] K_PEEK   = 3'd2;
  localparam logic [2:0] K_READ   = 3'd3;
  localparam logic [2:0] K_REMOVE = 3'd4;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] item;
    logic [5:0]  position;
  } dq_in_t;

  typedef struct packed {
    logic [31:0] data_out;
    logic [1:0]  status;
    logic [6:0]  occupancy;
  } dq_out_t;

  typedef struct packed {
    logic [2:0]            kind;
    logic                  at_back;
    logic [DATA_WIDTH-1:0] word;
    logic [PTR_W-1:0]      position;
  } dq_cmd_t;

  function automatic logic [PTR_W-1:0] dq_slot(input logic [PTR_W-1:0] front,
                                               input logic [CNT_W-1:0] offset);
    dq_slot = front + offset[PTR_W-1:0];
  endfunction

endpackage

// ===== sv/double_ended_queue.sv =====
// Bounded double-ended queue of 32-bit words in a 64-entry circular store.
// Depends on dq_pkg, dq_front, dq_queue and dq_back.
//
// Usage:
//   An item (opcode, item, position) is taken at a rising edge with start
//   high and busy low. busy rises while the two-entry command queue between
//   the decoder and the executing back end is full.
//   Every item yields one result (data_out, status, occupancy), shown on
//   out_data for one cycle while out_valid is high. The receiver cannot
//   stall; results leave in item order.
// From an accepted item to its result: each item is registered in the
//   command queue, then taken by the back end. A push and any item answered
//   without reading the store (full, empty, out of range, remove of zero,
//   remove from an empty queue) go straight to the result register; a pop,
//   peek or read index that reads the store waits in S_RD_WAIT for the
//   registered read of the single-read-port store. Remove of a nonzero word
//   scans entries up to the match, then moves each later entry toward the
//   front. Pushes sustain one item per cycle while the back end is idle.
// Reset:
//   rst_n low clears the count, front position, queue and result strobe.
`timescale 1ns / 1ps

module double_ended_queue
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    start,
  output logic    busy,
  input  dq_in_t  in_data,
  output logic    out_valid,
  output dq_out_t out_data
);

  dq_cmd_t front_cmd;
  dq_cmd_t head_cmd;
  logic    q_full;
  logic    q_not_empty;
  logic    q_pop;
  logic    accept;

  assign busy   = q_full;
  assign accept = start && !q_full;

  dq_front u_front (
    .in_item (in_data),
    .cmd     (front_cmd)
  );

  dq_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_cmd  (front_cmd),
    .pop       (q_pop),
    .full      (q_full),
    .not_empty (q_not_empty),
    .head      (head_cmd)
  );

  dq_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_valid (q_not_empty),
    .cmd       (head_cmd),
    .cmd_pop   (q_pop),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.occupancy <= 7'(DEPTH)))
    else $error("occupancy beyond depth");

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status != ST_OK) |-> (out_data.data_out == '0))
    else $error("nonzero data with error status");

  a_full_occ: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.status == ST_FULL) |-> (out_data.occupancy == 7'(DEPTH)))
    else $error("full status below depth");

  a_pop_needs_cmd: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_not_empty)
    else $error("command taken from empty queue");

endmodule

// ===== sv/dq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps

module dq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/dq_front.sv =====
// Front end: decodes an accepted item into a command for the back end.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_front
  import dq_pkg::*;
(
  input  dq_in_t  in_item,
  output dq_cmd_t cmd
);

  always_comb begin
    cmd.word     = in_item.item[DATA_WIDTH-1:0];
    cmd.position = in_item.position[PTR_W-1:0];
    cmd.at_back  = 1'b0;
    cmd.kind     = K_PUSH;
    unique case (in_item.opcode)
      OP_PUSH_FRONT: cmd.kind = K_PUSH;
      OP_PUSH_BACK: begin
        cmd.kind    = K_PUSH;
        cmd.at_back = 1'b1;
      end
      OP_POP_FRONT:  cmd.kind = K_POP;
      OP_POP_BACK: begin
        cmd.kind    = K_POP;
        cmd.at_back = 1'b1;
      end
      OP_PEEK_FRONT: cmd.kind = K_PEEK;
      OP_PEEK_BACK: begin
        cmd.kind    = K_PEEK;
        cmd.at_back = 1'b1;
      end
      OP_READ_INDEX: cmd.kind = K_READ;
      OP_REMOVE_VAL: cmd.kind = K_REMOVE;
      default:       cmd.kind = K_PUSH;
    endcase
  end

endmodule

// ===== sv/dq_queue.sv =====
// Short command queue between front and back ends.
// Depends on dq_pkg.
`timescale 1ns / 1ps

module dq_queue
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  dq_cmd_t push_cmd,
  input  logic    pop,
  output logic    full,
  output logic    not_empty,
  output dq_cmd_t head
);

  dq_cmd_t           slot_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wptr_r, wptr_nxt;
  logic [QPTR_W-1:0] rptr_r, rptr_nxt;
  logic [QCNT_W-1:0] cnt_r, cnt_nxt;

  assign full      = (cnt_r == QCNT_W'(QUEUE_DEPTH));
  assign not_empty = (cnt_r != '0);
  assign head      = slot_r[rptr_r];

  always_comb begin
    wptr_nxt = push ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = pop  ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wptr_r] <= push_cmd;
    end
  end

endmodule

// ===== sv/dq_back.sv =====
// Back end: executes commands on the circular entry store and emits results.
// Depends on dq_pkg and dq_ram.
`timescale 1ns / 1ps

module dq_back
  import dq_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    cmd_valid,
  input  dq_cmd_t cmd,
  output logic    cmd_pop,
  output logic    out_valid,
  output dq_out_t out_data
);

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_RD_WAIT  = 3'd1;
  localparam logic [2:0] S_SCAN_RD  = 3'd2;
  localparam logic [2:0] S_SCAN_CMP = 3'd3;
  localparam logic [2:0] S_SH_RD    = 3'd4;
  localparam logic [2:0] S_SH_WR    = 3'd5;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [PTR_W-1:0] front_r, front_nxt;
  logic [CNT_W-1:0] idx_r, idx_nxt;
  dq_cmd_t          cmd_r, cmd_nxt;
  logic             out_valid_r, out_valid_nxt;
  dq_out_t          out_r, out_nxt;

  logic                  ram_we;
  logic [PTR_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [PTR_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;
  logic [1:0]            res_status;
  logic [DATA_WIDTH-1:0] res_data;

  dq_ram #(.WIDTH(DATA_WIDTH), .DEPTH(DEPTH)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    front_nxt     = front_r;
    idx_nxt       = idx_r;
    cmd_nxt       = cmd_r;
    cmd_pop       = 1'b0;
    out_valid_nxt = 1'b0;
    res_status    = ST_OK;
    res_data      = '0;
    ram_we        = 1'b0;
    ram_waddr     = front_r;
    ram_wdata     = cmd_r.word;
    ram_raddr     = front_r;
    unique case (state_r)
      S_IDLE: begin
        if (cmd_valid) begin
          cmd_pop = 1'b1;
          cmd_nxt = cmd;
          case (cmd.kind)
            K_PUSH: begin
              out_valid_nxt = 1'b1;
              if (cnt_r == CNT_W'(DEPTH)) begin
                res_status = ST_FULL;
              end else begin
                ram_we    = 1'b1;
                ram_wdata = cmd.word;
                if (cmd.at_back) begin
                  ram_waddr = dq_slot(front_r, cnt_r);
                end else begin
                  ram_waddr = front_r - 1'b1;
                  front_nxt = front_r - 1'b1;
                end
                cnt_nxt = cnt_r + 1'b1;
              end
            end
            K_POP, K_PEEK: begin
              if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                res_status    = ST_EMPTY;
              end else begin
                ram_raddr = cmd.at_back ? dq_slot(front_r, cnt_r - 1'b1) : front_r;
                if (cmd.kind == K_POP) begin
                  cnt_nxt = cnt_r - 1'b1;
                  if (!cmd.at_back) begin
                    front_nxt = front_r + 1'b1;
                  end
                end
                state_nxt = S_RD_WAIT;
              end
            end
            K_READ: begin
              if (CNT_W'(cmd.position) >= cnt_r) begin
                out_valid_nxt = 1'b1;
                res_status    = ST_EMPTY;
              end else begin
                ram_raddr = dq_slot(front_r, CNT_W'(cmd.position));
                state_nxt = S_RD_WAIT;
              end
            end
            default: begin
              if (cmd.word == '0) begin
                out_valid_nxt = 1'b1;
              end else if (cnt_r == '0) begin
                out_valid_nxt = 1'b1;
                res_status    = ST_NOTFOUND;
              end else begin
                idx_nxt   = '0;
                state_nxt = S_SCAN_RD;
              end
            end
          endcase
        end
      end
      S_RD_WAIT: begin
        out_valid_nxt = 1'b1;
        res_data      = ram_rdata;
        state_nxt     = S_IDLE;
      end
      S_SCAN_RD: begin
        ram_raddr = dq_slot(front_r, idx_r);
        state_nxt = S_SCAN_CMP;
      end
      S_SCAN_CMP: begin
        if (ram_rdata == cmd_r.word) begin
          if (idx_r + 1'b1 < cnt_r) begin
            state_nxt = S_SH_RD;
          end else begin
            cnt_nxt       = cnt_r - 1'b1;
            out_valid_nxt = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (idx_r + 1'b1 >= cnt_r) begin
          out_valid_nxt = 1'b1;
          res_status    = ST_NOTFOUND;
          state_nxt     = S_IDLE;
        end else begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        ram_raddr = dq_slot(front_r, idx_r + 1'b1);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        ram_we    = 1'b1;
        ram_waddr = dq_slot(front_r, idx_r);
        ram_wdata = ram_rdata;
        if (idx_r + CNT_W'(2) < cnt_r) begin
          idx_nxt   = idx_r + 1'b1;
          state_nxt = S_SH_RD;
        end else begin
          cnt_nxt       = cnt_r - 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    out_nxt.data_out  = 32'(res_data);
    out_nxt.status    = res_status;
    out_nxt.occupancy = 7'(cnt_nxt);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      front_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      front_r     <= front_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r <= idx_nxt;
    cmd_r <= cmd_nxt;
    out_r <= out_nxt;
  end

endmodule
